/* hdl/sm83_pkg.sv */
`timescale 1ns / 1ps
package sm83_pkg;

	localparam int ADDR_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_EXEC  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  opcode;
		logic [7:0]  imm_lo;
		logic [7:0]  imm_hi;
		logic [15:0] mem_addr;
		logic [7:0]  mem_wdata;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  instr_length;
		logic [4:0]  cycle_count;
		logic        bad_opcode;
		logic [7:0]  out_a;
		logic [7:0]  out_f;
		logic [15:0] out_bc;
		logic [15:0] out_de;
		logic [15:0] out_hl;
		logic [15:0] out_sp;
		logic [15:0] out_pc;
		logic [7:0]  read_data;
	} out_item_t;

	// classification made by the front end
	typedef struct packed {
		in_item_t    item;
		logic        hl_src;
		logic        mem_op;
	} cls_t;

endpackage

/* hdl/sm83_instruction_execute_top.sv */
`timescale 1ns / 1ps
// channel   | signals                         | payload
// in        | in_valid / in_ready             | in_data  (sm83_pkg::in_item_t)
// out       | out_valid / out_ready           | out_data (sm83_pkg::out_item_t)
// An item goes through the execute sequencer: ST_IDLE takes it from the queue, ST_RD
// reads memory when the item touches memory, ST_EXEC executes, ST_WR2 writes the high
// byte of LD (a16),SP, ST_OUT loads the output register; one memory port needs ST_WR2.
// The output register loads only once the previous result is taken.
// A two-entry queue takes new items while the back end works or the output stalls.
// Reset clears the registers; memory content is undefined until written.
module sm83_instruction_execute_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sm83_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sm83_pkg::out_item_t out_data
);
	logic           q_valid, q_ready;
	sm83_pkg::cls_t q_data;

	sm83_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	sm83_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

/* hdl/sm83_front.sv */
`timescale 1ns / 1ps
module sm83_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sm83_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output sm83_pkg::cls_t    q_data
);
	sm83_pkg::cls_t ent_q [sm83_pkg::QUEUE_DEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	sm83_pkg::cls_t cls;
	logic           push, pop;

	// classify: does the item touch memory
	always_comb begin
		cls.item = in_data;
		cls.hl_src = 1'b0;
		cls.mem_op = (in_data.mode != sm83_pkg::MODE_EXEC);
		if (in_data.mode == sm83_pkg::MODE_EXEC && in_data.opcode < 8'h70) begin
			if (in_data.opcode >= 8'h40)
				cls.hl_src = (in_data.opcode[2:0] == 3'd6) || (in_data.opcode[5:3] == 3'd6);
			else if (in_data.opcode[2:0] == 3'd4 || in_data.opcode[2:0] == 3'd5
				|| in_data.opcode[2:0] == 3'd6)
				cls.hl_src = (in_data.opcode[5:3] == 3'd6);
			cls.mem_op = cls.hl_src || in_data.opcode[3:0] == 4'h2
				|| in_data.opcode[3:0] == 4'hA || in_data.opcode == 8'h08;
		end
	end

	assign in_ready = (cnt_q != 2'(sm83_pkg::QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = ent_q[rp_q];

	// hold queue entries
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= cls;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hdl/sm83_back.sv */
`timescale 1ns / 1ps
module sm83_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  sm83_pkg::cls_t      q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sm83_pkg::out_item_t out_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EXEC, ST_WR2, ST_OUT} state_t;

	state_t         state_q;
	sm83_pkg::cls_t cur_q;
	logic [7:0]     mem [2**sm83_pkg::ADDR_BITS];
	logic [7:0]     rdata_q;
	logic [7:0]     a_q, f_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0]    sp_q, pc_q;
	logic           out_valid_q;
	sm83_pkg::out_item_t out_q;
	logic [1:0]     len_q;
	logic [4:0]     cyc_q;
	logic           bad_q;
	logic [7:0]     rd_q;

	logic [7:0]  op, lo, hi;
	logic [2:0]  row;
	logic [1:0]  p;
	logic [15:0] bc, de, hl, pr, raddr16;

	assign op = cur_q.item.opcode;
	assign lo = cur_q.item.imm_lo;
	assign hi = cur_q.item.imm_hi;
	assign row = op[5:3];
	assign p = op[5:4];
	assign bc = {b_q, c_q};
	assign de = {d_q, e_q};
	assign hl = {h_q, l_q};

	always_comb begin
		case (p)
			2'd0: pr = bc;
			2'd1: pr = de;
			2'd2: pr = hl;
			default: pr = sp_q;
		endcase
	end

	// pick the address for the memory access
	always_comb begin
		if (cur_q.item.mode != sm83_pkg::MODE_EXEC) raddr16 = cur_q.item.mem_addr;
		else if (cur_q.hl_src) raddr16 = hl;
		else if (op < 8'h40 && p == 2'd0) raddr16 = bc;
		else if (op < 8'h40 && p == 2'd1) raddr16 = de;
		else raddr16 = hl;
	end

	// next state of the register file and memory write
	logic [7:0]  na, nf, nb, nc, nd, ne, nh, nl;
	logic [15:0] nsp, npc;
	logic        we, we2;
	logic [15:0] waddr;
	logic [7:0]  wdata;
	logic [1:0]  len;
	logic [4:0]  cyc;
	logic        bad;

	function automatic logic [7:0] rd8(input logic [2:0] i, input logic [7:0] m,
		input logic [7:0] ra, rb, rc, rd, re, rh, rl);
		case (i)
			3'd0: return rb;
			3'd1: return rc;
			3'd2: return rd;
			3'd3: return re;
			3'd4: return rh;
			3'd5: return rl;
			3'd6: return m;
			default: return ra;
		endcase
	endfunction

	always_comb begin
		logic [7:0]  v, av;
		logic [16:0] sum;
		logic [12:0] hs;
		logic [15:0] tmp;
		logic        jump, fz, fn, fh, fc, dc;
		logic        wr_r8;
		logic [2:0]  dst;
		na = a_q; nf = f_q; nb = b_q; nc = c_q; nd = d_q; ne = e_q; nh = h_q; nl = l_q;
		nsp = sp_q; npc = pc_q;
		we = 1'b0; waddr = hl; wdata = 8'd0;
		len = 2'd1; cyc = 5'd4; bad = 1'b0;
		jump = 1'b0; v = 8'd0; wr_r8 = 1'b0; dst = row;
		fz = f_q[7]; fn = f_q[6]; fh = f_q[5]; fc = f_q[4];
		sum = 17'd0; hs = 13'd0; tmp = 16'd0; av = a_q; dc = fc;
		if (op >= 8'h70) begin
			len = 2'd0; cyc = 5'd0; bad = 1'b1;
		end else if (op >= 8'h40) begin
			v = rd8(op[2:0], rdata_q, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
			wr_r8 = 1'b1;
			cyc = (op[2:0] == 3'd6) ? 5'd8 : 5'd4;
		end else if (op[2:0] == 3'd4 || op[2:0] == 3'd5) begin
			v = rd8(row, rdata_q, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
			if (op[0]) begin
				v = v - 8'd1;
				nf = {v == 8'd0, 1'b1, v[3:0] == 4'hF, fc, 4'd0};
			end else begin
				v = v + 8'd1;
				nf = {v == 8'd0, 1'b0, v[3:0] == 4'h0, fc, 4'd0};
			end
			wr_r8 = 1'b1;
			cyc = (row == 3'd6) ? 5'd12 : 5'd4;
		end else if (op[2:0] == 3'd6) begin
			v = lo; wr_r8 = 1'b1; len = 2'd2;
			cyc = (row == 3'd6) ? 5'd12 : 5'd8;
		end else if (op[3:0] == 4'h1) begin
			tmp = {hi, lo}; len = 2'd3; cyc = 5'd12;
		end else if (op[3:0] == 4'h2 || op[3:0] == 4'hA) begin
			if (op[3:0] == 4'h2) begin
				we = 1'b1; waddr = raddr16; wdata = a_q;
			end else na = rdata_q;
			if (p == 2'd2) {nh, nl} = hl + 16'd1;
			if (p == 2'd3) {nh, nl} = hl - 16'd1;
			cyc = 5'd8;
		end else if (op[3:0] == 4'h3 || op[3:0] == 4'hB) begin
			tmp = op[3] ? pr - 16'd1 : pr + 16'd1; cyc = 5'd8;
		end else if (op[3:0] == 4'h9) begin
			sum = {1'b0, hl} + {1'b0, pr};
			hs = {1'b0, hl[11:0]} + {1'b0, pr[11:0]};
			nf = {fz, 1'b0, hs[12], sum[16], 4'd0};
			{nh, nl} = sum[15:0];
			cyc = 5'd8;
		end else begin
			case (op)
				8'h00: ;
				8'h10: len = 2'd2;
				8'h08: begin
					we = 1'b1; waddr = {hi, lo}; wdata = sp_q[7:0];
					len = 2'd3; cyc = 5'd20;
				end
				8'h18: jump = 1'b1;
				8'h20: jump = !fz;
				8'h28: jump = fz;
				8'h30: jump = !fc;
				8'h38: jump = fc;
				8'h07: begin na = {a_q[6:0], a_q[7]}; nf = {3'd0, a_q[7], 4'd0}; end
				8'h0F: begin na = {a_q[0], a_q[7:1]}; nf = {3'd0, a_q[0], 4'd0}; end
				8'h17: begin na = {a_q[6:0], fc}; nf = {3'd0, a_q[7], 4'd0}; end
				8'h1F: begin na = {fc, a_q[7:1]}; nf = {3'd0, a_q[0], 4'd0}; end
				8'h27: begin
					if (!fn) begin
						if (fc || a_q > 8'h99) begin av = av + 8'h60; dc = 1'b1; end
						if (fh || av[3:0] > 4'd9) av = av + 8'h06;
					end else begin
						if (fc) av = av - 8'h60;
						if (fh) av = av - 8'h06;
					end
					na = av;
					nf = {av == 8'd0, fn, 1'b0, dc, 4'd0};
				end
				8'h2F: begin na = ~a_q; nf = {fz, 2'b11, fc, 4'd0}; end
				8'h37: nf = {fz, 2'b00, 1'b1, 4'd0};
				default: nf = {fz, 2'b00, !fc, 4'd0};
			endcase
			if (op[2:0] == 3'd0 && row >= 3'd3) begin
				len = 2'd2; cyc = jump ? 5'd12 : 5'd8;
			end
		end
		if (op < 8'h40 && (op[3:0] == 4'h1 || op[3:0] == 4'h3 || op[3:0] == 4'hB)) begin
			case (p)
				2'd0: {nb, nc} = tmp;
				2'd1: {nd, ne} = tmp;
				2'd2: {nh, nl} = tmp;
				default: nsp = tmp;
			endcase
		end
		if (wr_r8) begin
			case (dst)
				3'd0: nb = v;
				3'd1: nc = v;
				3'd2: nd = v;
				3'd3: ne = v;
				3'd4: nh = v;
				3'd5: nl = v;
				3'd6: begin we = 1'b1; waddr = hl; wdata = v; end
				default: na = v;
			endcase
		end
		npc = pc_q + 16'(len);
		if (jump) npc = npc + {{8{lo[7]}}, lo};
		we2 = (op == 8'h08);
	end

	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// memory port: one read, one write per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) rdata_q <= mem[raddr16[sm83_pkg::ADDR_BITS-1:0]];
		if (state_q == ST_EXEC && cur_q.item.mode == sm83_pkg::MODE_WRITE)
			mem[cur_q.item.mem_addr[sm83_pkg::ADDR_BITS-1:0]] <= cur_q.item.mem_wdata;
		else if (state_q == ST_EXEC && cur_q.item.mode == sm83_pkg::MODE_EXEC && we)
			mem[waddr[sm83_pkg::ADDR_BITS-1:0]] <= wdata;
		else if (state_q == ST_WR2)
			mem[sm83_pkg::ADDR_BITS'({hi, lo} + 16'd1)] <= sp_q[15:8];
	end

	// sequence one item: read, execute, second write, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			a_q <= 8'd0; f_q <= 8'd0; b_q <= 8'd0; c_q <= 8'd0;
			d_q <= 8'd0; e_q <= 8'd0; h_q <= 8'd0; l_q <= 8'd0;
			sp_q <= 16'd0; pc_q <= 16'd0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (q_valid) begin
					cur_q <= q_data;
					state_q <= q_data.mem_op ? ST_RD : ST_EXEC;
				end
				ST_RD: state_q <= ST_EXEC;
				ST_EXEC: begin
					rd_q <= (cur_q.item.mode == sm83_pkg::MODE_READ) ? rdata_q : 8'd0;
					len_q <= (cur_q.item.mode == sm83_pkg::MODE_EXEC) ? len : 2'd0;
					cyc_q <= (cur_q.item.mode == sm83_pkg::MODE_EXEC) ? cyc : 5'd0;
					bad_q <= (cur_q.item.mode == sm83_pkg::MODE_EXEC) && bad;
					if (cur_q.item.mode == sm83_pkg::MODE_EXEC) begin
						a_q <= na; f_q <= nf; b_q <= nb; c_q <= nc; d_q <= nd; e_q <= ne;
						h_q <= nh; l_q <= nl; sp_q <= nsp;
						if (!bad) pc_q <= npc;
					end
					state_q <= (cur_q.item.mode == sm83_pkg::MODE_EXEC && we2) ? ST_WR2 : ST_OUT;
				end
				ST_WR2: state_q <= ST_OUT;
				ST_OUT: if (!out_valid_q || out_ready) begin
					out_q.read_data <= rd_q;
					out_q.instr_length <= len_q;
					out_q.cycle_count <= cyc_q;
					out_q.bad_opcode <= bad_q;
					out_q.out_a <= a_q; out_q.out_f <= {f_q[7:4], 4'd0};
					out_q.out_bc <= bc; out_q.out_de <= de; out_q.out_hl <= hl;
					out_q.out_sp <= sp_q; out_q.out_pc <= pc_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
